### rtl/core/vld_pkg.sv
// Shared types and constants for the vibration latch detector.
// Used by every module under rtl/core; it depends on nothing else.
package vld_pkg;

   // Register map: the word index is byte address bits [3:2].
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SHAKE_THRESHOLD = 2'd0,
      REG_CONFIRM_COUNT   = 2'd1,
      REG_RELEASE_COUNT   = 2'd2,
      REG_GLITCH_LIMIT    = 2'd3
   } reg_index_type;

   // Register reset values.
   localparam logic [15:0] THRESHOLD_RESET = 16'd8192;
   localparam logic [7:0]  CONFIRM_RESET   = 8'd5;
   localparam logic [7:0]  RELEASE_RESET   = 8'd5;
   localparam logic [14:0] GLITCH_RESET    = 15'd32000;

   // Item kinds on the request channel.
   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   // Run counters saturate at this value.
   localparam logic [7:0] RUN_MAX = 8'hFF;

   typedef struct packed {
      logic [15:0] shake_threshold;
      logic [7:0]  confirm_count;
      logic [7:0]  release_count;
      logic [14:0] glitch_limit;
   } cfg_type;

   // Last accepted sample, one signed word per axis.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } axes_type;

   // Outcome of evaluating one sample against the previous one.
   typedef struct packed {
      axes_type sample;   // sample after glitch replacement
      logic     exceed;   // some axis difference is above the threshold
   } eval_type;

   // Flags carried by one result item.
   typedef struct packed {
      logic shake_latched;
      logic shake_pending;
      logic report_shake;
   } status_type;

endpackage

### rtl/core/vld_csr.sv
// Configuration register file on an APB-style port.
// Depends on vld_pkg for the register map and the configuration struct.
module vld_csr
   import vld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Write decode: only the addressed register takes the new value.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_SHAKE_THRESHOLD: cfg_in.shake_threshold = csr_pwdata[15:0];
            REG_CONFIRM_COUNT:   cfg_in.confirm_count   = csr_pwdata[7:0];
            REG_RELEASE_COUNT:   cfg_in.release_count   = csr_pwdata[7:0];
            REG_GLITCH_LIMIT:    cfg_in.glitch_limit    = csr_pwdata[14:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shake_threshold <= THRESHOLD_RESET;
         cfg_ff.confirm_count   <= CONFIRM_RESET;
         cfg_ff.release_count   <= RELEASE_RESET;
         cfg_ff.glitch_limit    <= GLITCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode, zero-extended to the data width.
   always_comb begin
      unique case (index)
         REG_SHAKE_THRESHOLD: csr_prdata = {16'd0, cfg_ff.shake_threshold};
         REG_CONFIRM_COUNT:   csr_prdata = {24'd0, cfg_ff.confirm_count};
         REG_RELEASE_COUNT:   csr_prdata = {24'd0, cfg_ff.release_count};
         REG_GLITCH_LIMIT:    csr_prdata = {17'd0, cfg_ff.glitch_limit};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/vld_eval.sv
// Sample evaluation: glitch rejection and per-axis absolute differences.
// Purely combinational; depends on vld_pkg for the axis and result structs.
module vld_eval
   import vld_pkg::*;
(
   input  axes_type    sample,
   input  axes_type    prev,
   input  logic [15:0] shake_threshold,
   input  logic [14:0] glitch_limit,
   output eval_type    result
);

   logic [16:0] mag_x, mag_y, mag_z;
   logic        glitch;
   axes_type    chosen;
   logic signed [16:0] diff_x, diff_y, diff_z;
   logic [16:0] abs_x, abs_y, abs_z;
   logic [16:0] thresh_ext;

   // Axis magnitudes at 17 bits so the most negative value reads as 32768.
   always_comb begin
      mag_x = sample.x[15] ? 17'(-{sample.x[15], sample.x}) : {1'b0, sample.x};
      mag_y = sample.y[15] ? 17'(-{sample.y[15], sample.y}) : {1'b0, sample.y};
      mag_z = sample.z[15] ? 17'(-{sample.z[15], sample.z}) : {1'b0, sample.z};
   end

   // A glitch on any axis replaces the whole sample with the previous one.
   assign glitch = (mag_x > {2'b00, glitch_limit}) ||
                   (mag_y > {2'b00, glitch_limit}) ||
                   (mag_z > {2'b00, glitch_limit});
   assign chosen = glitch ? prev : sample;

   // Exact signed differences, then magnitudes of up to 65535.
   always_comb begin
      diff_x = {chosen.x[15], chosen.x} - {prev.x[15], prev.x};
      diff_y = {chosen.y[15], chosen.y} - {prev.y[15], prev.y};
      diff_z = {chosen.z[15], chosen.z} - {prev.z[15], prev.z};
      abs_x  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
      abs_y  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
      abs_z  = diff_z[16] ? 17'(-diff_z) : 17'(diff_z);
   end

   assign thresh_ext    = {1'b0, shake_threshold};
   assign result.sample = chosen;
   assign result.exceed = (abs_x > thresh_ext) || (abs_y > thresh_ext) ||
                          (abs_z > thresh_ext);

endmodule

### rtl/core/vld_track.sv
// Detector state: previous sample, run counters, shake latch and pending flag.
// Depends on vld_pkg; the evaluation comes from vld_eval.
module vld_track
   import vld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  kind_type   kind,
   input  eval_type   eval,
   input  logic [7:0] confirm_count,
   input  logic [7:0] release_count,
   output axes_type   prev,
   output status_type status
);

   axes_type   prev_ff, prev_in;
   logic [7:0] exceed_run_ff, exceed_run_in;
   logic [7:0] quiet_run_ff, quiet_run_in;
   logic       latch_ff, latch_in;
   logic       pending_ff, pending_in;
   logic       report;
   logic [7:0] exceed_inc;
   logic [7:0] quiet_inc;

   assign exceed_inc = (exceed_run_ff < RUN_MAX) ? exceed_run_ff + 8'd1 : exceed_run_ff;
   assign quiet_inc  = (quiet_run_ff < RUN_MAX) ? quiet_run_ff + 8'd1 : quiet_run_ff;

   // Next state for the item in the input register.
   always_comb begin
      prev_in       = prev_ff;
      exceed_run_in = exceed_run_ff;
      quiet_run_in  = quiet_run_ff;
      latch_in      = latch_ff;
      pending_in    = pending_ff;
      report        = 1'b0;
      unique case (kind)
         KIND_REPORT: begin
            report     = latch_ff | pending_ff;
            pending_in = 1'b0;
         end
         KIND_SAMPLE: begin
            prev_in = eval.sample;
            if (eval.exceed) begin
               exceed_run_in = exceed_inc;
               quiet_run_in  = '0;
               if (exceed_inc >= confirm_count) begin
                  latch_in   = 1'b1;
                  pending_in = 1'b1;
               end
            end else begin
               exceed_run_in = '0;
               if (latch_ff) begin
                  quiet_run_in = quiet_inc;
                  if (quiet_inc >= release_count) begin
                     latch_in     = 1'b0;
                     quiet_run_in = '0;
                     pending_in   = 1'b0;
                  end
               end
            end
         end
         default: begin
            report = 1'b0;
         end
      endcase
   end

   // State moves only when the item passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         exceed_run_ff <= '0;
         quiet_run_ff  <= '0;
         latch_ff      <= 1'b0;
         pending_ff    <= 1'b0;
      end else if (advance) begin
         prev_ff       <= prev_in;
         exceed_run_ff <= exceed_run_in;
         quiet_run_ff  <= quiet_run_in;
         latch_ff      <= latch_in;
         pending_ff    <= pending_in;
      end
   end

   assign prev                 = prev_ff;
   assign status.shake_latched = latch_in;
   assign status.shake_pending = pending_in;
   assign status.report_shake  = report;

endmodule

### rtl/core/vibration_latch_detector.sv
// Top level of the vibration latch detector: input register, evaluation,
// state tracking and result register. Depends on vld_pkg, vld_csr,
// vld_eval and vld_track.
//
// Usage: each request item is either an accelerometer sample (kind 0,
// three signed 16-bit axes) or a report read (kind 1). Every item gives
// exactly one response item with the shake latch and pending flag after
// that item, plus report_shake, which a report read sets to latch OR
// pending before pending is cleared.
// Both channels use valid/ready. An accepted item is held in the input
// register, is evaluated there and moves into the result register when
// that is free, so the response is offered from the result register and
// is held there until it is taken.
// Throughput is one item per cycle unless stalled: the state update is a
// single pass of subtract, compare and counter logic between the registers.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; req_ready drops only when both are
// full, and rises again in the cycle the response is taken.
// Reset (synchronous) empties both registers, clears the previous sample,
// counters and flags, and loads the register defaults. The user must write
// registers on the csr_ port only while no item is in flight; not enforced.
module vibration_latch_detector
   import vld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic signed [15:0]    req_accel_x,
   input  logic signed [15:0]    req_accel_y,
   input  logic signed [15:0]    req_accel_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_shake_latched,
   output logic                  rsp_shake_pending,
   output logic                  rsp_report_shake,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   kind_type   in_kind_ff;
   axes_type   in_axes_ff;
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff;
   status_type status;
   axes_type   prev;
   eval_type   eval;
   logic       advance;
   logic       accept;

   vld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline control: the input item moves on when the result slot is free.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff   <= kind_type'(req_kind);
         in_axes_ff.x <= req_accel_x;
         in_axes_ff.y <= req_accel_y;
         in_axes_ff.z <= req_accel_z;
      end
   end

   vld_eval u_eval (
      .sample          (in_axes_ff),
      .prev            (prev),
      .shake_threshold (cfg.shake_threshold),
      .glitch_limit    (cfg.glitch_limit),
      .result          (eval)
   );

   vld_track u_track (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .kind          (in_kind_ff),
      .eval          (eval),
      .confirm_count (cfg.confirm_count),
      .release_count (cfg.release_count),
      .prev          (prev),
      .status        (status)
   );

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_shake_latched = out_status_ff.shake_latched;
   assign rsp_shake_pending = out_status_ff.shake_pending;
   assign rsp_report_shake  = out_status_ff.report_shake;

endmodule
